// ----- hw/rtl/sth_pkg.sv -----
package sth_pkg;

	localparam int OUTER_ROUNDS_DEF = 3;
	localparam int TEA_ITERS_DEF = 5;

	localparam int WORD_W = 32;
	localparam int CFG_IDX_W = 8;

	localparam logic [WORD_W-1:0] ROUND_CONST_BASE = 32'hFFFF_FFFC;
	localparam logic [43:0] Z_SEQUENCE = 44'h938_BCA3_083F;
	localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 8'd3;

	typedef logic [WORD_W-1:0] word_t;

	// block halves plus the four running round keys
	typedef struct packed {
		word_t lo;
		word_t hi;
		word_t [3:0] rk;
	} sth_data_t;

	function automatic word_t rotl(input word_t x, input int unsigned r);
		return (x << r) | (x >> (WORD_W - r));
	endfunction

	function automatic word_t simeck_f(input word_t x);
		return (x & rotl(x, 5)) ^ rotl(x, 1);
	endfunction

	// running TEA sum after round n (n counts from 1), modulo 2^32
	function automatic word_t tea_sum(input int unsigned n);
		logic [63:0] p;
		p = 64'(n) * 64'(TEA_DELTA);
		return p[WORD_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/sth_simeck_stage.sv -----
module sth_simeck_stage
	import sth_pkg::*;
#(
	parameter logic ZBIT = 1'b0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      up_valid,
	input  sth_data_t up_data,
	output logic      valid_s1,
	output sth_data_t data_s1
);

	word_t     round_const;
	sth_data_t nxt;

	assign round_const = ROUND_CONST_BASE | {{(WORD_W-1){1'b0}}, ZBIT};

	// block round, key schedule step, then rotate keys 1..3
	always_comb begin
		nxt.hi    = simeck_f(up_data.hi) ^ up_data.lo ^ up_data.rk[0];
		nxt.lo    = up_data.hi;
		nxt.rk[0] = up_data.rk[1];
		nxt.rk[1] = up_data.rk[2];
		nxt.rk[2] = up_data.rk[3];
		nxt.rk[3] = simeck_f(up_data.rk[1]) ^ up_data.rk[0] ^ round_const;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- hw/rtl/sth_tea_stage.sv -----
module sth_tea_stage
	import sth_pkg::*;
#(
	parameter logic  Z_HALF = 1'b0,
	parameter word_t SUM    = TEA_DELTA
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      up_valid,
	input  sth_data_t up_data,
	output logic      valid_s1,
	output sth_data_t data_s1
);

	word_t     src;
	word_t     dst;
	word_t     ka;
	word_t     kb;
	word_t     mix;
	sth_data_t nxt;

	// y half reads z and keys 0/1, z half reads y and keys 2/3
	assign src = Z_HALF ? up_data.lo : up_data.hi;
	assign dst = Z_HALF ? up_data.hi : up_data.lo;
	assign ka  = Z_HALF ? up_data.rk[2] : up_data.rk[0];
	assign kb  = Z_HALF ? up_data.rk[3] : up_data.rk[1];
	assign mix = ((src << 4) + ka) ^ (src + SUM) ^ ((src >> 5) + kb);

	always_comb begin
		nxt = up_data;
		if (Z_HALF) begin
			nxt.hi = dst + mix;
		end else begin
			nxt.lo = dst + mix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ----- hw/rtl/simeck_tea_hybrid_encrypt_top.sv -----
// Pipeline: one register per Simeck round and one per TEA half round,
//   the TEA halves about two 32-bit adds deep.
// Throughput: one block per cycle; the whole pipe holds while a result waits.
// Reset: arst_n clears all stage valid bits and the four key words to zero.
module simeck_tea_hybrid_encrypt_top
	import sth_pkg::*;
#(
	parameter int OUTER_ROUNDS = OUTER_ROUNDS_DEF,
	parameter int TEA_ITERS    = TEA_ITERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// block input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_W-1:0]    plain_left,
	input  logic [WORD_W-1:0]    plain_right,
	// ciphertext output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    cipher_left,
	output logic [WORD_W-1:0]    cipher_right,
	// key register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	// stages per outer round: one Simeck round, then a y and a z half per TEA round
	localparam int PER_OUTER = 1 + 2 * TEA_ITERS;
	localparam int NS        = OUTER_ROUNDS * PER_OUTER;

	word_t key_q [4];

	logic      advance;
	logic      vld [NS+1];
	sth_data_t dat [NS+1];

	// Key registers: writes are always taken, indexes past the last key drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_WORD_0: key_q[0] <= cfg_data;
				REG_KEY_WORD_1: key_q[1] <= cfg_data;
				REG_KEY_WORD_2: key_q[2] <= cfg_data;
				REG_KEY_WORD_3: key_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The last stage is the output register. Every stage moves together unless
	// a finished result sits there and the downstream side stalls; then the
	// whole pipe holds, bubbles included. An idle output never blocks intake.
	assign advance  = !vld[NS] || !out_stall;
	assign in_stall = !advance;

	// stage 0: the incoming beat and the master key, no register
	assign vld[0]      = in_valid;
	assign dat[0].lo    = plain_left;
	assign dat[0].hi    = plain_right;
	assign dat[0].rk[0] = key_q[0];
	assign dat[0].rk[1] = key_q[1];
	assign dat[0].rk[2] = key_q[2];
	assign dat[0].rk[3] = key_q[3];

	for (genvar r = 0; r < OUTER_ROUNDS; r++) begin : g_outer
		localparam int BASE = r * PER_OUTER;

		// Simeck round with key-schedule step; z bit r of the sequence
		sth_simeck_stage #(
			.ZBIT (Z_SEQUENCE[r])
		) u_simeck (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.up_valid (vld[BASE]),
			.up_data  (dat[BASE]),
			.valid_s1 (vld[BASE+1]),
			.data_s1  (dat[BASE+1])
		);

		// TEA rounds, sum restarting from zero each outer round
		for (genvar t = 0; t < TEA_ITERS; t++) begin : g_tea
			localparam int    Y_IDX = BASE + 1 + 2 * t;
			localparam word_t SUM_T = tea_sum(t + 1);

			sth_tea_stage #(
				.Z_HALF (1'b0),
				.SUM    (SUM_T)
			) u_tea_y (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (advance),
				.up_valid (vld[Y_IDX]),
				.up_data  (dat[Y_IDX]),
				.valid_s1 (vld[Y_IDX+1]),
				.data_s1  (dat[Y_IDX+1])
			);

			sth_tea_stage #(
				.Z_HALF (1'b1),
				.SUM    (SUM_T)
			) u_tea_z (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (advance),
				.up_valid (vld[Y_IDX+1]),
				.up_data  (dat[Y_IDX+1]),
				.valid_s1 (vld[Y_IDX+2]),
				.data_s1  (dat[Y_IDX+2])
			);
		end
	end

	assign out_valid    = vld[NS];
	assign cipher_left  = dat[NS].lo;
	assign cipher_right = dat[NS].hi;

	// an accepted beat lands in the first stage on the next edge
	a_intake_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld[1])
		else $error("accepted block did not enter the first stage");

	// intake is held back only by a stalled result in the output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("intake stalled without a waiting result");

	// a full last-but-one stage moves into the output when the pipe advances
	a_tail_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[NS-1] && !in_stall) |=> out_valid)
		else $error("block lost between final stage and output");

	// a held result stays valid until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(cipher_left)
			&& $stable(cipher_right)))
		else $error("stalled result changed or dropped");

endmodule
